>>> rtl/core/fca_pkg.sv
// fca_pkg: shared types, constants and a saturating increment for the FAT chain auditor.
// Used by fca_seq, fat_chain_auditor_unit and the dv benches. No dependencies.
package fca_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_WALK   = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	localparam logic [0:0] REG_LIMIT = 1'b0;
	localparam logic [0:0] REG_MEDIA = 1'b1;

	localparam logic [15:0] EOC12     = 16'h0FF8;
	localparam logic [15:0] EOC16     = 16'hFFF8;
	localparam logic [15:0] MASK12    = 16'h0FFF;
	localparam logic [16:0] FAT16_LIM = 17'd4087;  // 4085 clusters plus two reserved
	localparam logic [15:0] SAT       = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] fat_byte_index;
		logic [7:0]  fat_byte;
		logic [15:0] start_cluster;
		logic [15:0] need_clusters;
	} fca_in_t;

	typedef struct packed {
		logic        chain_ok;
		logic [15:0] chain_length;
		logic [15:0] chain_cross_links;
		logic [15:0] lost_clusters;
		logic [15:0] free_clusters;
		logic [15:0] used_clusters;
		logic [15:0] cross_link_total;
		logic [15:0] bad_chain_total;
		logic        media_mismatch;
		logic        needs_repair;
	} fca_out_t;

	// saturating increment of a 16-bit total
	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == SAT) ? v : v + 16'd1;
	endfunction

endpackage

>>> rtl/core/fca_seq.sv
// fca_seq: sequencer, FAT byte memory and used bitmap of the auditor.
// Depends on fca_pkg. One read port each, one table entry per two byte reads.
module fca_seq #(
	parameter int MAX_CLUSTERS = 32768,
	parameter int FAT_BYTES    = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  fca_pkg::fca_in_t        word_in,
	input  logic [15:0]             cluster_limit,
	input  logic [7:0]              media_byte,
	output logic                    busy,
	output logic                    done,
	output fca_pkg::fca_out_t       word_out
);
	import fca_pkg::*;

	localparam int AW = $clog2(FAT_BYTES);
	localparam int CW = $clog2(MAX_CLUSTERS);
	localparam int LW = CW + 1;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_WIPE  = 10'b0000000010,
		S_RD0   = 10'b0000000100,
		S_RD1   = 10'b0000001000,
		S_RD2   = 10'b0000010000,
		S_RD3   = 10'b0000100000,
		S_WALK  = 10'b0001000000,
		S_CHECK = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [7:0] fat_mem [FAT_BYTES];
	logic       mark_mem [MAX_CLUSTERS];

	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic [CW-1:0] mk_addr;
	logic          mk_we;
	logic          mk_data_q;

	logic [16:0] cur_q;       // cluster being visited (or scanned)
	logic [16:0] lim_q;
	logic        f16_q;
	logic        fin_q;       // finish scan vs walk
	logic [15:0] need_q;
	logic [16:0] len_q, xl_q, steps_q, lost_q, free_q;
	logic [7:0]  lo_q;
	logic [15:0] entry_q;
	logic        ok_q, mm_q;
	logic [15:0] used_q, cross_q, bad_q;
	logic        rep_q;
	logic [CW-1:0] wipe_q;
	logic          mk_cur_q;

	// effective limit and table layout
	logic [16:0] lim_eff;
	assign lim_eff = ({1'b0, cluster_limit} > 17'(MAX_CLUSTERS)) ? 17'(MAX_CLUSTERS)
		: {1'b0, cluster_limit};

	logic [17:0] off0;
	assign off0 = f16_q ? {cur_q, 1'b0} : 18'(cur_q) + 18'(cur_q[16:1]);
	logic [17:0] off_rd;
	assign off_rd = (state_q == S_RD0) ? off0 : off0 + 18'd1;
	logic        off_ok;
	assign off_ok = off_rd < 18'(FAT_BYTES);

	// raw entry from the two bytes
	logic [15:0] raw;
	logic [15:0] ent;
	assign raw = {(off_ok ? rd_data_q : 8'd0), lo_q};
	assign ent = f16_q ? raw : (cur_q[0] ? ((raw >> 4) & MASK12) : (raw & MASK12));

	logic cur_bad;
	assign cur_bad = (cur_q < 17'd2) || (cur_q >= lim_q);

	assign rd_addr = off_rd[AW-1:0];
	assign mk_addr = (state_q == S_WIPE) ? wipe_q : cur_q[CW-1:0];

	// byte store with one write and one read port, bitmap with one port, registered read
	always_ff @(posedge clk) begin
		if (go && word_in.operation == OP_LOAD &&
		    {1'b0, word_in.fat_byte_index} < 17'(FAT_BYTES))
			fat_mem[word_in.fat_byte_index[AW-1:0]] <= word_in.fat_byte;
		rd_data_q <= fat_mem[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (mk_we)
			mark_mem[mk_addr] <= (state_q == S_RD2);
		mk_data_q <= mark_mem[mk_addr];
	end

	assign mk_we = (state_q == S_WIPE) || (state_q == S_RD2 && !fin_q && !mk_data_q);
	assign busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			wipe_q  <= '0;
			used_q  <= '0;
			cross_q <= '0;
			bad_q   <= '0;
			rep_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						cur_q   <= {1'b0, word_in.start_cluster};
						need_q  <= word_in.need_clusters;
						lim_q   <= lim_eff;
						f16_q   <= lim_eff >= FAT16_LIM;
						len_q   <= '0; xl_q <= '0; steps_q <= '0;
						lost_q  <= '0; free_q <= '0;
						ok_q    <= 1'b1; mm_q <= 1'b0;
						unique case (word_in.operation)
							OP_CLEAR: begin
								wipe_q  <= '0;
								used_q  <= '0; cross_q <= '0; bad_q <= '0;
								rep_q   <= 1'b0;
								state_q <= S_WIPE;
							end
							OP_LOAD: state_q <= S_IDLE;
							OP_WALK: begin
								fin_q   <= 1'b0;
								state_q <= S_WALK;
							end
							default: begin
								fin_q   <= 1'b1;
								cur_q   <= '0;
								state_q <= S_RD0;
							end
						endcase
					end
				end
				S_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == CW'(MAX_CLUSTERS - 1)) state_q <= S_IDLE;
				end
				S_WALK: begin
					// step check: empty, out of range, endless
					if (cur_q == '0 && len_q == '0) begin
						if (need_q != '0) begin
							ok_q <= 1'b0; bad_q <= sat_inc(bad_q); rep_q <= 1'b1;
						end
						state_q <= S_DONE;
					end else if (steps_q >= lim_q || cur_bad) begin
						ok_q <= 1'b0; bad_q <= sat_inc(bad_q); rep_q <= 1'b1;
						state_q <= S_DONE;
					end else
						state_q <= S_RD0;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					lo_q    <= (off0 < 18'(FAT_BYTES)) ? rd_data_q : 8'd0;
					state_q <= S_RD2;
				end
				S_RD2: begin
					entry_q  <= ent;
					mk_cur_q <= mk_data_q;
					state_q  <= S_RD3;
				end
				S_RD3: state_q <= fin_q ? S_FIN : S_CHECK;
				S_CHECK: begin
					if (mk_cur_q) begin
						xl_q <= xl_q + 1'b1; cross_q <= sat_inc(cross_q); rep_q <= 1'b1;
					end else
						used_q <= sat_inc(used_q);
					len_q <= len_q + 1'b1;
					if (entry_q >= (f16_q ? EOC16 : EOC12)) begin
						if ({1'b0, need_q} > len_q + 17'd1) begin
							ok_q <= 1'b0; bad_q <= sat_inc(bad_q); rep_q <= 1'b1;
						end
						state_q <= S_DONE;
					end else if (entry_q == '0) begin
						ok_q <= 1'b0; bad_q <= sat_inc(bad_q); rep_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						cur_q   <= {1'b0, entry_q};
						steps_q <= steps_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_FIN: begin
					// entry zero: media check, then scan clusters 2 .. limit-1
					if (cur_q == '0) begin
						if (entry_q[7:0] != media_byte) begin
							mm_q <= 1'b1; rep_q <= 1'b1;
						end
						cur_q <= 17'd2;
						state_q <= (lim_q > 17'd2) ? S_RD0 : S_DONE;
					end else begin
						if (entry_q != '0 && !mk_cur_q) begin
							lost_q <= lost_q + 1'b1; rep_q <= 1'b1;
						end
						if (entry_q == '0) free_q <= free_q + 1'b1;
						cur_q   <= cur_q + 1'b1;
						state_q <= (cur_q + 17'd1 < lim_q) ? S_RD0 : S_DONE;
					end
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word; all counts fit 16 bits at these limits
	always_comb begin
		word_out.chain_ok          = fin_q ? 1'b0 : ok_q;
		word_out.chain_length      = fin_q ? 16'd0 : ((len_q > 17'(SAT)) ? SAT : len_q[15:0]);
		word_out.chain_cross_links = fin_q ? 16'd0 : ((xl_q > 17'(SAT)) ? SAT : xl_q[15:0]);
		word_out.lost_clusters     = fin_q ? ((lost_q > 17'(SAT)) ? SAT : lost_q[15:0]) : 16'd0;
		word_out.free_clusters     = fin_q ? ((free_q > 17'(SAT)) ? SAT : free_q[15:0]) : 16'd0;
		word_out.used_clusters     = used_q;
		word_out.cross_link_total  = cross_q;
		word_out.bad_chain_total   = bad_q;
		word_out.media_mismatch    = fin_q & mm_q;
		word_out.needs_repair      = rep_q;
	end

	// a result word only ends a busy period
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("done without finish state");
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(go)) else $error("start taken while busy");
	a_wipe_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WIPE && wipe_q != CW'(MAX_CLUSTERS - 1) |=> state_q == S_WIPE)
		else $error("wipe cut short");
endmodule

>>> rtl/core/fat_chain_auditor_unit.sv
// fat_chain_auditor_unit: top level of the FAT12/FAT16 chain auditor.
// Depends on fca_pkg and fca_seq.
//
// A load writes its byte and leaves busy low. A walk keeps busy high while it visits
// each cluster, paced by the byte store's single read port (two byte reads per
// entry). A finish keeps busy high while it scans the table, one table entry per
// pass, with the limit clamped to MAX_CLUSTERS. A clear, and reset, sweep the used
// bitmap one bit a cycle, and busy stays high for the whole sweep. The result word
// shows for one cycle with done high, in the same cycle that busy drops, and
// cannot be stalled by the receiver.
module fat_chain_auditor_unit #(
	parameter int MAX_CLUSTERS = 32768,
	parameter int FAT_BYTES    = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fca_pkg::fca_in_t  word_in,
	output logic              done,
	output fca_pkg::fca_out_t word_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import fca_pkg::*;

	logic [15:0] limit_q;
	logic [7:0]  media_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd2;
			media_q <= 8'd248;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LIMIT: limit_q <= cfg_data;
				default:   media_q <= cfg_data[7:0];
			endcase
		end
	end

	fca_seq #(.MAX_CLUSTERS(MAX_CLUSTERS), .FAT_BYTES(FAT_BYTES)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (start && !busy),
		.word_in       (word_in),
		.cluster_limit (limit_q),
		.media_byte    (media_q),
		.busy          (busy),
		.done          (done),
		.word_out      (word_out)
	);
endmodule

>>> dv/fca_audit_monitor.sv
// fca_audit_monitor: watches the auditor's command, result and register channels,
// predicts every result word and compares it field by field. Depends on fca_pkg.
module fca_audit_monitor
	import fca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  fca_in_t     word_in,
	input  logic        done,
	input  fca_out_t    word_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the block: table bytes, used bitmap, totals, registers
	logic [7:0]  table_img [65536];
	bit          used_map [32768];
	int          used_tot, xlink_tot, bad_tot;
	bit          repair;
	logic [15:0] limit_reg;
	logic [7:0]  media_reg;
	fca_out_t    audit_reports [$];

	initial begin
		errors = 0;
		outstanding = 0;
		foreach (table_img[i]) table_img[i] = '0;
	end

	function automatic int sat_add(input int v);
		return (v < 65535) ? v + 1 : v;
	endfunction

	function automatic int live_limit();
		return (limit_reg > 16'd32768) ? 32768 : int'(limit_reg);
	endfunction

	function automatic int byte_at(input int i);
		return (i < 65536) ? int'(table_img[i]) : 0;
	endfunction

	// FAT12 entries straddle bytes on odd clusters; FAT16 entries are two whole bytes
	function automatic int entry_at(input int c);
		int off, v;
		if (live_limit() >= 4087) begin
			off = c * 2;
			return byte_at(off) | (byte_at(off + 1) << 8);
		end
		off = c + c / 2;
		v = byte_at(off) | (byte_at(off + 1) << 8);
		return (c % 2 == 1) ? ((v >> 4) & 'hFFF) : (v & 'hFFF);
	endfunction

	function automatic void flag_bad();
		bad_tot = sat_add(bad_tot);
		repair = 1'b1;
	endfunction

	// Updates the shadow for one command word; returns 1 when it yields a result.
	function automatic bit audit_word(input fca_in_t w, output fca_out_t r);
		int  lim, c, nxt, eoc, steps, len, xl, lost, freec;
		bit  ok, fin, mm;
		r = '0;
		lim = live_limit();
		len = 0;
		xl = 0;
		lost = 0;
		freec = 0;
		ok = 1'b0;
		mm = 1'b0;
		case (w.operation)
			OP_CLEAR: begin
				foreach (used_map[i]) used_map[i] = 1'b0;
				used_tot = 0;
				xlink_tot = 0;
				bad_tot = 0;
				repair = 1'b0;
				return 1'b0;
			end
			OP_LOAD: begin
				table_img[w.fat_byte_index] = w.fat_byte;
				return 1'b0;
			end
			OP_WALK: begin
				c = w.start_cluster;
				eoc = (lim >= 4087) ? int'(EOC16) : int'(EOC12);
				ok = 1'b1;
				fin = 1'b0;
				steps = 0;
				if (c == 0) begin
					if (w.need_clusters > 0) begin
						ok = 1'b0;
						flag_bad();
					end
					fin = 1'b1;
				end
				while (!fin && steps < lim) begin
					if (c < 2 || c >= lim) begin
						ok = 1'b0;
						flag_bad();
						fin = 1'b1;
					end else begin
						if (used_map[c]) begin
							xl++;
							xlink_tot = sat_add(xlink_tot);
							repair = 1'b1;
						end else begin
							used_map[c] = 1'b1;
							used_tot = sat_add(used_tot);
						end
						len++;
						nxt = entry_at(c);
						if (nxt >= eoc) begin
							if (len < w.need_clusters) begin
								ok = 1'b0;
								flag_bad();
							end
							fin = 1'b1;
						end else if (nxt == 0) begin
							ok = 1'b0;
							flag_bad();
							fin = 1'b1;
						end else begin
							c = nxt;
							steps++;
						end
					end
				end
				// ran out of steps without an end mark
				if (!fin) begin
					ok = 1'b0;
					flag_bad();
				end
			end
			default: begin
				if ((entry_at(0) & 'hFF) != int'(media_reg)) begin
					mm = 1'b1;
					repair = 1'b1;
				end
				for (c = 2; c < lim; c++) begin
					nxt = entry_at(c);
					if (nxt != 0 && !used_map[c]) begin
						lost++;
						repair = 1'b1;
					end
					if (nxt == 0) freec++;
				end
			end
		endcase
		r.chain_ok          = ok;
		r.chain_length      = 16'(len);
		r.chain_cross_links = 16'(xl);
		r.lost_clusters     = 16'(lost);
		r.free_clusters     = 16'(freec);
		r.used_clusters     = 16'(used_tot);
		r.cross_link_total  = 16'(xlink_tot);
		r.bad_chain_total   = 16'(bad_tot);
		r.media_mismatch    = mm;
		r.needs_repair      = repair;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endfunction

	// result words first, then register writes, then the new command word
	always @(posedge clk or negedge arst_n) begin
		fca_out_t want, fresh;
		if (!arst_n) begin
			foreach (used_map[i]) used_map[i] = 1'b0;
			used_tot = 0;
			xlink_tot = 0;
			bad_tot = 0;
			repair = 1'b0;
			limit_reg = 16'd2;
			media_reg = 8'd248;
			audit_reports.delete();
		end else begin
			if (done) begin
				if (audit_reports.size() == 0) begin
					$error("result word with nothing outstanding");
					errors++;
				end else begin
					want = audit_reports.pop_front();
					check_field("chain_ok", want.chain_ok, word_out.chain_ok);
					check_field("chain_length", want.chain_length, word_out.chain_length);
					check_field("chain_cross_links", want.chain_cross_links,
						word_out.chain_cross_links);
					check_field("lost_clusters", want.lost_clusters, word_out.lost_clusters);
					check_field("free_clusters", want.free_clusters, word_out.free_clusters);
					check_field("used_clusters", want.used_clusters, word_out.used_clusters);
					check_field("cross_link_total", want.cross_link_total,
						word_out.cross_link_total);
					check_field("bad_chain_total", want.bad_chain_total,
						word_out.bad_chain_total);
					check_field("media_mismatch", want.media_mismatch, word_out.media_mismatch);
					check_field("needs_repair", want.needs_repair, word_out.needs_repair);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LIMIT: limit_reg = cfg_data;
					REG_MEDIA: media_reg = cfg_data[7:0];
				endcase
			end
			if (start && !busy) begin
				if (audit_word(word_in, fresh)) audit_reports.push_back(fresh);
			end
		end
		outstanding = audit_reports.size();
	end

endmodule

>>> dv/tb_fat_chain_auditor_unit.sv
// tb_fat_chain_auditor_unit: builds FAT12/FAT16 tables with random chains and faults,
// drives loads, walks, finishes and clears; fca_audit_monitor does the checking.
module tb_fat_chain_auditor_unit;
	import fca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 600000;
	localparam int SPAN_MAX    = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	fca_in_t     word_in;
	logic        done;
	fca_out_t    word_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          outstanding;

	fat_chain_auditor_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.word_in  (word_in),
		.done     (done),
		.word_out (word_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	fca_audit_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.word_in    (word_in),
		.done       (done),
		.word_out   (word_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stimulus-side table image and chain bookkeeping
	logic [7:0] disk_img [65536];
	int         next_link [32768];
	int         chain_heads [$];
	int         cyc, stall_cnt;
	int         n_walk, n_finish, n_load, n_clear;

	// watchdog: cycles with no word moving on any channel
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// sender gaps, except in a quiet window at the start of each period of cyc
	task automatic maybe_idle();
		if ((cyc % 8192) >= 2048 && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [1:0] op, input int idx, input int val,
		input int sc, input int need);
		fca_in_t w;
		w.operation      = op;
		w.fat_byte_index = 16'(idx);
		w.fat_byte       = 8'(val);
		w.start_cluster  = 16'(sc);
		w.need_clusters  = 16'(need);
		maybe_idle();
		word_in <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		case (op)
			OP_WALK:   n_walk++;
			OP_FINISH: n_finish++;
			OP_LOAD:   n_load++;
			default:   n_clear++;
		endcase
	endtask

	// drop start and wait for every result, then for the block to go idle
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic put_entry(input int c, input int v, input bit wide);
		int off;
		if (wide) begin
			disk_img[2 * c]     = 8'(v);
			disk_img[2 * c + 1] = 8'(v >> 8);
		end else begin
			off = c + c / 2;
			if (c % 2 == 1) begin
				disk_img[off]     = {4'(v), disk_img[off][3:0]};
				disk_img[off + 1] = 8'(v >> 4);
			end else begin
				disk_img[off]     = 8'(v);
				disk_img[off + 1] = {disk_img[off + 1][7:4], 4'(v >> 8)};
			end
		end
	endtask

	// random chains with end marks, free clusters and a few broken links; only entries
	// below span are built and loaded, and only fault links reach past them
	task automatic build_table(input int lim, input int span, input int media,
		input bit media_ok);
		int  order [$];
		int  i, k, n, len, eoc, h, nb, tmp, j;
		bit  wide;
		wide = (lim >= 4087);
		eoc = wide ? int'(EOC16) : int'(EOC12);
		chain_heads.delete();
		for (i = 0; i < span; i++) next_link[i] = 0;
		for (i = 2; i < span; i++) order.push_back(i);
		n = order.size();
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		i = 0;
		while (i < n) begin
			if ($urandom_range(4) == 0) begin
				i++;
			end else begin
				len = $urandom_range(1, 7);
				if (i + len > n) len = n - i;
				chain_heads.push_back(order[i]);
				for (k = 0; k < len - 1; k++) next_link[order[i + k]] = order[i + k + 1];
				next_link[order[i + len - 1]] = eoc + $urandom_range(7);
				i += len;
			end
		end
		// faults: zero link, out-of-range link, self loop (small tables only)
		for (k = 0; k < 2 + n / 40 && k < 12 && chain_heads.size() > 0; k++) begin
			h = chain_heads[$urandom_range(chain_heads.size() - 1)];
			case ($urandom_range(lim <= 5000 ? 2 : 1))
				0: next_link[h] = 0;
				1: next_link[h] = ($urandom_range(1) == 0) ? 1 : $urandom_range(lim, eoc - 1);
				default: next_link[h] = h;
			endcase
		end
		next_link[0] = (wide ? 'hFF00 : 'hF00) |
			(media_ok ? media : (media ^ $urandom_range(1, 255)));
		next_link[1] = eoc + 7;
		for (i = 0; i < span; i++) put_entry(i, next_link[i], wide);
		nb = wide ? 2 * span : span + span / 2 + 2;
		if (nb > 65536) nb = 65536;
		for (i = 0; i < nb; i++) issue(OP_LOAD, i, disk_img[i], $urandom(), $urandom());
	endtask

	// finishes and random loads only where the whole table is loaded
	task automatic random_traffic(input int lim, input int span, input int count);
		int k, r, sc, need;
		bit big, full;
		big = (lim > 5000);
		full = (span == lim);
		for (k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 55 && chain_heads.size() > 0) begin
				sc = chain_heads[$urandom_range(chain_heads.size() - 1)];
				need = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom();
				issue(OP_WALK, $urandom(), $urandom(), sc, need);
			end else if (r < 70) begin
				sc = (span > 2) ? $urandom_range(2, span - 1) : 0;
				issue(OP_WALK, $urandom(), $urandom(), sc, $urandom_range(4));
			end else if (r < 80) begin
				case ($urandom_range(3))
					0: sc = 0;
					1: sc = 1;
					2: sc = lim;
					default: sc = $urandom_range(lim, 65535);
				endcase
				issue(OP_WALK, $urandom(), $urandom(), sc, $urandom());
			end else if (r < 88 && full) begin
				issue(OP_LOAD, $urandom(), $urandom(), $urandom(), $urandom());
			end else if (r < 96 && full) begin
				issue(OP_FINISH, $urandom(), $urandom(), $urandom(), $urandom());
			end else if (r == 96 && !big) begin
				issue(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				issue(OP_WALK, $urandom(), $urandom(), 0, $urandom_range(1));
			end
		end
	endtask

	initial begin
		int limits [8] = '{3, 40, 300, 4086, 4087, 5000, 32768, 65535};
		int medias [8] = '{0, 255, 'h5A, 'hF8, 'hF0, 'hF8, 'hF9, 'hF9};
		int counts [8] = '{40, 90, 70, 50, 50, 50, 60, 40};
		int p, lim, span, built;
		arst_n = 1'b0;
		start = 1'b0;
		word_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LIMIT;
		cfg_data = '0;
		cyc = 0;
		stall_cnt = 0;
		n_walk = 0;
		n_finish = 0;
		n_load = 0;
		n_clear = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset registers, entry zero, empty and out-of-range starts
		issue(OP_LOAD, 0, 'hF8, 0, 0);
		issue(OP_LOAD, 1, 'hFF, 0, 0);
		issue(OP_LOAD, 2, 'hFF, 0, 0);
		issue(OP_LOAD, 3, 'h00, 0, 0);
		issue(OP_LOAD, 65535, 'hA5, 'hFFFF, 'hFFFF);
		issue(OP_WALK, 0, 0, 0, 0);
		issue(OP_WALK, 0, 0, 0, 1);
		issue(OP_WALK, 0, 0, 0, 65535);
		issue(OP_WALK, 0, 0, 1, 0);
		issue(OP_WALK, 0, 0, 2, 1);
		issue(OP_WALK, 0, 0, 65535, 65535);
		issue(OP_FINISH, 0, 0, 0, 0);
		issue(OP_LOAD, 0, 'h00, 0, 0);
		issue(OP_FINISH, 0, 0, 0, 0);
		issue(OP_CLEAR, 0, 0, 0, 0);
		issue(OP_FINISH, 65535, 255, 65535, 65535);

		// one phase per limit setting, FAT12 and FAT16, up to an oversized limit
		built = -1;
		for (p = 0; p < 8; p++) begin
			write_reg(REG_LIMIT, limits[p]);
			write_reg(REG_MEDIA, medias[p]);
			lim = (limits[p] > 32768) ? 32768 : limits[p];
			span = (lim < SPAN_MAX) ? lim : SPAN_MAX;
			if (p % 2 == 0) issue(OP_CLEAR, 0, 0, 0, 0);
			if (lim != built) begin
				build_table(lim, span, medias[p], $urandom_range(3) != 0);
				built = lim;
			end
			random_traffic(lim, span, counts[p]);
			if (span == lim) issue(OP_FINISH, $urandom(), $urandom(), $urandom(), $urandom());
		end

		settle();
		repeat (64) @(posedge clk);
		$display("ran %0d walks, %0d finishes, %0d clears, %0d table loads", n_walk,
			n_finish, n_clear, n_load);
		$display("limits 2 to 65535 over FAT12 and FAT16 tables with broken chains");
		if (errors == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> fat_chain_auditor_unit.f
rtl/core/fca_pkg.sv
rtl/core/fca_seq.sv
rtl/core/fat_chain_auditor_unit.sv
dv/fca_audit_monitor.sv
dv/tb_fat_chain_auditor_unit.sv
